>>> hdl/rlcseg_pkg.sv
// ----------------------------------------------------------------------------
// rlcseg_pkg
// Shared types and codes of the UM RLC transmit segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcseg_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned SEQ_BITS_DEF    = 10;

	typedef enum logic [1:0] {
		ACT_ENQ = 2'd0,
		ACT_PDU = 2'd1,
		ACT_REM = 2'd2,
		ACT_CLR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_ENQ    = 2'd0,
		KIND_SEG    = 2'd1,
		KIND_CLOSE  = 2'd2,
		KIND_REMCLR = 2'd3
	} kind_t;

	localparam logic [2:0] BURST_NONE     = 3'd0;
	localparam logic [2:0] BURST_INACTIVE = 3'd1;
	localparam logic [2:0] BURST_ACTIVE   = 3'd2;
	localparam logic [2:0] BURST_START    = 3'd3;
	localparam logic [2:0] BURST_STOP     = 3'd4;

	localparam logic [1:0] REG_LIMIT = 2'd0;
	localparam logic [1:0] REG_HDR   = 2'd1;
	localparam logic [1:0] REG_BURST = 2'd2;

	typedef struct packed {
		logic [23:0] limit;
		logic [3:0]  hdr;
		logic        burst_en;
	} cfg_t;

	typedef struct packed {
		action_t     act;
		logic [15:0] total;
		logic [15:0] payload;
		logic [31:0] seq;
		logic [19:0] grant;
	} item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ,
		ST_REM_RD,
		ST_REM_EMIT,
		ST_CLR,
		ST_PDU_INIT,
		ST_PDU_RD,
		ST_PDU_USE,
		ST_PDU_CLOSE
	} back_state_t;

endpackage

`default_nettype wire

>>> hdl/rlcseg_front.sv
// ----------------------------------------------------------------------------
// rlcseg_front
// Accepts request beats, decodes the action and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcseg_front import rlcseg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] sdu_total_bytes,
	input  wire logic [15:0] sdu_payload_bytes,
	input  wire logic [31:0] sdu_seq,
	input  wire logic [19:0] pdu_bytes,
	output logic             item_valid,
	output item_t            item,
	input  wire logic        item_deq
);

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        do_push;
	logic        do_pop;
	item_t       in_item;

	always_comb begin
		in_item.act     = action_t'(action);
		in_item.total   = sdu_total_bytes;
		in_item.payload = sdu_payload_bytes;
		in_item.seq     = sdu_seq;
		in_item.grant   = pdu_bytes;
	end

	assign full       = cnt_q == 2'd2;
	assign item_valid = cnt_q != 2'd0;
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_deq && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("front queue count out of range");

endmodule

`default_nettype wire

>>> hdl/rlcseg_back.sv
// ----------------------------------------------------------------------------
// rlcseg_back
// Executes one request at a time against the SDU descriptor store and
// places results in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcseg_back import rlcseg_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned SEQ_BITS    = SEQ_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfg_t                cfg,
	input  wire logic                item_valid,
	input  wire item_t               item,
	output logic                     item_deq,
	output logic                     empty,
	input  wire logic                pop,
	output logic [1:0]               kind,
	output logic                     accepted,
	output logic [31:0]              sdu_seq_out,
	output logic [15:0]              segment_bytes,
	output logic [SEQ_BITS-1:0]      pdu_seq,
	output logic [1:0]               framing_info,
	output logic [19:0]              pdu_total_bytes,
	output logic                     empty_pdu,
	output logic [2:0]               burst_mark,
	output logic [23:0]              queued_bytes_out,
	output logic                     last
);

	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned TW = CW + 1;

	// store entry: {seq, payload, total}
	logic [63:0]         store [QUEUE_DEPTH];
	logic [63:0]         rdata_q;

	back_state_t         state_q, state_d;
	item_t               cur_q;

	// committed queue state
	logic [IW-1:0]       head_q;
	logic [CW-1:0]       cnt_q;
	logic [23:0]         qbytes_q;
	logic [15:0]         frag_rem_q;
	logic                frag_valid_q;
	logic                first_frag_q;
	logic [SEQ_BITS-1:0] next_seq_q;
	logic                burst_q;

	// working copy used while walking the queue for a PDU
	logic [IW-1:0]       w_head_q;
	logic [CW-1:0]       w_cnt_q;
	logic [23:0]         w_qbytes_q;
	logic [15:0]         w_rem_q;
	logic                w_fv_q;
	logic                w_first_q;
	logic signed [20:0]  w_avail_q;
	logic [20:0]         w_len_q;
	logic                w_end_q;
	logic                pass2_q;
	logic [23:0]         final_qb_q;

	logic                out_valid_q;
	logic                out_free;
	logic                emit;
	logic                rd_en;
	logic [IW-1:0]       rd_addr;
	logic                wr_en;

	// derived values
	logic [TW-1:0]       tail_sum;
	logic [IW-1:0]       tail_idx;
	logic [TW-1:0]       last_sum;
	logic [IW-1:0]       last_idx;
	logic [24:0]         enq_sum;
	logic                enq_ok;
	logic                walk_more;
	logic [15:0]         slen;
	logic                fits;
	logic [15:0]         take;
	logic [15:0]         ent_total;
	logic [23:0]         sub_qb;
	logic [23:0]         rem_qb;
	logic [IW-1:0]       w_head_inc;
	logic signed [20:0]  avail_init;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;

	always_comb begin
		tail_sum = TW'(head_q) + TW'(cnt_q);
		if (tail_sum >= TW'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - TW'(QUEUE_DEPTH);
		end
		tail_idx = tail_sum[IW-1:0];
		last_sum = TW'(head_q) + TW'(cnt_q) - TW'(1);
		if (last_sum >= TW'(QUEUE_DEPTH)) begin
			last_sum = last_sum - TW'(QUEUE_DEPTH);
		end
		last_idx = last_sum[IW-1:0];
	end

	assign enq_sum = {1'b0, qbytes_q} + {9'd0, cur_q.total};
	assign enq_ok  = (cnt_q < CW'(QUEUE_DEPTH)) && !enq_sum[24] &&
		((cfg.limit == 24'd0) || (enq_sum[23:0] < cfg.limit));

	assign walk_more  = (w_cnt_q != CW'(0)) && !w_avail_q[20] && (w_avail_q != 21'sd0);
	assign slen       = w_fv_q ? w_rem_q : rdata_q[31:16];
	assign fits       = w_avail_q[19:0] >= {4'd0, slen};
	assign take       = fits ? slen : w_avail_q[15:0];
	assign ent_total  = rdata_q[15:0];
	assign sub_qb     = ({8'd0, ent_total} > w_qbytes_q) ? 24'd0 : w_qbytes_q - {8'd0, ent_total};
	assign rem_qb     = ({8'd0, ent_total} > qbytes_q) ? 24'd0 : qbytes_q - {8'd0, ent_total};
	assign w_head_inc = (w_head_q == IW'(QUEUE_DEPTH - 1)) ? IW'(0) : w_head_q + IW'(1);
	assign avail_init = $signed({1'b0, cur_q.grant}) - $signed({17'd0, cfg.hdr});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item.act)
						ACT_ENQ: state_d = ST_ENQ;
						ACT_PDU: state_d = ST_PDU_INIT;
						ACT_REM: state_d = ST_REM_RD;
						default: state_d = ST_CLR;
					endcase
				end
			end
			ST_ENQ:      if (out_free) state_d = ST_IDLE;
			ST_REM_RD:   state_d = ST_REM_EMIT;
			ST_REM_EMIT: if (out_free) state_d = ST_IDLE;
			ST_CLR:      if (out_free) state_d = ST_IDLE;
			ST_PDU_INIT: state_d = ST_PDU_RD;
			ST_PDU_RD: begin
				if (walk_more) begin
					state_d = ST_PDU_USE;
				end else if (!pass2_q) begin
					state_d = ST_PDU_INIT;
				end else begin
					state_d = ST_PDU_CLOSE;
				end
			end
			ST_PDU_USE:   if (!pass2_q || out_free) state_d = ST_PDU_RD;
			ST_PDU_CLOSE: if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_deq = 1'b0;
		emit     = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = w_head_q;
		wr_en    = 1'b0;
		case (state_q)
			ST_IDLE:      item_deq = item_valid;
			ST_ENQ: begin
				emit  = out_free;
				wr_en = out_free && enq_ok;
			end
			ST_REM_RD: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
			end
			ST_REM_EMIT:  emit = out_free;
			ST_CLR:       emit = out_free;
			ST_PDU_RD:    rd_en = walk_more;
			ST_PDU_USE:   emit = pass2_q && out_free;
			ST_PDU_CLOSE: emit = out_free;
			default:      emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[tail_idx] <= {cur_q.seq, cur_q.payload, cur_q.total};
		end
		if (rd_en) begin
			rdata_q <= store[rd_addr];
		end
		if (state_q == ST_IDLE && item_valid) begin
			cur_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			cnt_q        <= '0;
			qbytes_q     <= '0;
			frag_rem_q   <= '0;
			frag_valid_q <= 1'b0;
			first_frag_q <= 1'b0;
			next_seq_q   <= '0;
			burst_q      <= 1'b0;
			w_head_q     <= '0;
			w_cnt_q      <= '0;
			w_qbytes_q   <= '0;
			w_rem_q      <= '0;
			w_fv_q       <= 1'b0;
			w_first_q    <= 1'b0;
			w_avail_q    <= '0;
			w_len_q      <= '0;
			w_end_q      <= 1'b0;
			pass2_q      <= 1'b0;
			final_qb_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: pass2_q <= 1'b0;
				ST_ENQ: begin
					if (out_free && enq_ok) begin
						cnt_q    <= cnt_q + CW'(1);
						qbytes_q <= enq_sum[23:0];
					end
				end
				ST_REM_EMIT: begin
					if (out_free && cnt_q != CW'(0)) begin
						cnt_q    <= cnt_q - CW'(1);
						qbytes_q <= rem_qb;
						if (cnt_q == CW'(1) && frag_valid_q) begin
							frag_valid_q <= 1'b0;
							frag_rem_q   <= '0;
							first_frag_q <= 1'b0;
						end
					end
				end
				ST_CLR: begin
					if (out_free) begin
						cnt_q        <= '0;
						head_q       <= '0;
						qbytes_q     <= '0;
						frag_valid_q <= 1'b0;
						frag_rem_q   <= '0;
						first_frag_q <= 1'b0;
					end
				end
				ST_PDU_INIT: begin
					w_head_q   <= head_q;
					w_cnt_q    <= cnt_q;
					w_qbytes_q <= qbytes_q;
					w_rem_q    <= frag_rem_q;
					w_fv_q     <= frag_valid_q;
					w_first_q  <= first_frag_q;
					w_avail_q  <= avail_init;
					w_len_q    <= '0;
					w_end_q    <= 1'b0;
				end
				ST_PDU_RD: begin
					// first pass only finds the final byte count
					if (!walk_more && !pass2_q) begin
						pass2_q    <= 1'b1;
						final_qb_q <= w_qbytes_q;
					end
				end
				ST_PDU_USE: begin
					if (!pass2_q || out_free) begin
						w_len_q <= w_len_q + {5'd0, take};
						if (fits) begin
							w_avail_q  <= w_avail_q - $signed({5'd0, slen});
							w_fv_q     <= 1'b0;
							w_rem_q    <= '0;
							w_head_q   <= w_head_inc;
							w_cnt_q    <= w_cnt_q - CW'(1);
							w_qbytes_q <= sub_qb;
							w_first_q  <= 1'b0;
						end else begin
							w_avail_q <= '0;
							w_rem_q   <= slen - take;
							w_fv_q    <= 1'b1;
							w_end_q   <= 1'b1;
							w_first_q <= 1'b1;
						end
					end
				end
				ST_PDU_CLOSE: begin
					if (out_free) begin
						head_q       <= w_head_q;
						cnt_q        <= w_cnt_q;
						qbytes_q     <= w_qbytes_q;
						frag_rem_q   <= w_rem_q;
						frag_valid_q <= w_fv_q;
						first_frag_q <= w_first_q;
						if (w_len_q != 21'd0) begin
							next_seq_q <= next_seq_q + SEQ_BITS'(1);
							if (cfg.burst_en) begin
								burst_q <= w_cnt_q != CW'(0);
							end
						end
					end
				end
				default: pass2_q <= pass2_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit) begin
			kind             <= KIND_ENQ;
			accepted         <= 1'b0;
			sdu_seq_out      <= '0;
			segment_bytes    <= '0;
			pdu_seq          <= '0;
			framing_info     <= '0;
			pdu_total_bytes  <= '0;
			empty_pdu        <= 1'b0;
			burst_mark       <= BURST_NONE;
			last             <= 1'b1;
			queued_bytes_out <= qbytes_q;
			case (state_q)
				ST_ENQ: begin
					accepted    <= enq_ok;
					sdu_seq_out <= cur_q.seq;
					if (enq_ok) begin
						queued_bytes_out <= enq_sum[23:0];
					end
				end
				ST_REM_EMIT: begin
					kind <= KIND_REMCLR;
					if (cnt_q != CW'(0)) begin
						accepted         <= 1'b1;
						sdu_seq_out      <= rdata_q[63:32];
						queued_bytes_out <= rem_qb;
					end
				end
				ST_CLR: begin
					kind             <= KIND_REMCLR;
					accepted         <= 1'b1;
					queued_bytes_out <= '0;
				end
				ST_PDU_USE: begin
					kind             <= KIND_SEG;
					sdu_seq_out      <= rdata_q[63:32];
					segment_bytes    <= take;
					last             <= 1'b0;
					queued_bytes_out <= final_qb_q;
				end
				ST_PDU_CLOSE: begin
					kind             <= KIND_CLOSE;
					queued_bytes_out <= w_qbytes_q;
					if (w_len_q == 21'd0) begin
						empty_pdu <= 1'b1;
					end else begin
						pdu_seq         <= next_seq_q;
						framing_info    <= {first_frag_q, w_end_q};
						pdu_total_bytes <= 20'({17'd0, cfg.hdr} + w_len_q);
						if (cfg.burst_en) begin
							if (w_cnt_q == CW'(0)) begin
								burst_mark <= burst_q ? BURST_STOP : BURST_INACTIVE;
							end else begin
								burst_mark <= burst_q ? BURST_ACTIVE : BURST_START;
							end
						end
					end
				end
				default: last <= 1'b1;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above store depth");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == CW'(0)) |-> (qbytes_q == 24'd0))
		else $error("bytes left on empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) frag_valid_q |-> (cnt_q != CW'(0)))
		else $error("fragment kept without head entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PDU_USE) |-> (w_cnt_q != CW'(0)))
		else $error("segment taken from empty working queue");

endmodule

`default_nettype wire

>>> hdl/rlc_um_tx_segmenter.sv
// ----------------------------------------------------------------------------
// rlc_um_tx_segmenter
// UM RLC transmit segmenter: SDU descriptor queue with PDU building.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   push / full          action, sdu_*, pdu_bytes
//  result    empty / pop          kind .. last
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Enqueue and clear pass through the ENQ or CLR state to the result beat;
//  remove reads the store in REM_RD, then emits in REM_EMIT. A PDU request
//  walks the queue twice, reading (PDU_RD) and using (PDU_USE) the store
//  entry for each segment in each pass, then closes in PDU_CLOSE.
//  A full output register holds the engine; the front queue keeps taking
//  beats until its two entries are filled. Reset clears all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module rlc_um_tx_segmenter import rlcseg_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned SEQ_BITS    = SEQ_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [1:0]          action,
	input  wire logic [15:0]         sdu_total_bytes,
	input  wire logic [15:0]         sdu_payload_bytes,
	input  wire logic [31:0]         sdu_seq,
	input  wire logic [19:0]         pdu_bytes,
	output logic                     empty,
	input  wire logic                pop,
	output logic [1:0]               kind,
	output logic                     accepted,
	output logic [31:0]              sdu_seq_out,
	output logic [15:0]              segment_bytes,
	output logic [SEQ_BITS-1:0]      pdu_seq,
	output logic [1:0]               framing_info,
	output logic [19:0]              pdu_total_bytes,
	output logic                     empty_pdu,
	output logic [2:0]               burst_mark,
	output logic [23:0]              queued_bytes_out,
	output logic                     last,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [23:0]         cfg_data
);

	cfg_t  cfg_q;
	logic  item_valid;
	item_t item;
	logic  item_deq;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit    <= 24'd0;
			cfg_q.hdr      <= 4'd2;
			cfg_q.burst_en <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIMIT: cfg_q.limit    <= cfg_data;
				REG_HDR:   cfg_q.hdr      <= cfg_data[3:0];
				REG_BURST: cfg_q.burst_en <= cfg_data[0];
				default:   cfg_q          <= cfg_q;
			endcase
		end
	end

	rlcseg_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.action            (action),
		.sdu_total_bytes   (sdu_total_bytes),
		.sdu_payload_bytes (sdu_payload_bytes),
		.sdu_seq           (sdu_seq),
		.pdu_bytes         (pdu_bytes),
		.item_valid        (item_valid),
		.item              (item),
		.item_deq          (item_deq)
	);

	rlcseg_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.SEQ_BITS    (SEQ_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.item_valid       (item_valid),
		.item             (item),
		.item_deq         (item_deq),
		.empty            (empty),
		.pop              (pop),
		.kind             (kind),
		.accepted         (accepted),
		.sdu_seq_out      (sdu_seq_out),
		.segment_bytes    (segment_bytes),
		.pdu_seq          (pdu_seq),
		.framing_info     (framing_info),
		.pdu_total_bytes  (pdu_total_bytes),
		.empty_pdu        (empty_pdu),
		.burst_mark       (burst_mark),
		.queued_bytes_out (queued_bytes_out),
		.last             (last)
	);

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench of the UM RLC transmit segmenter: directed table then
// random SDU/PDU traffic, every result beat checked against a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import rlcseg_pkg::*;

	localparam int DEPTH    = 16;
	localparam int CYC_MAX  = 400000;

	typedef struct packed {
		logic [1:0]  kind;
		logic        accepted;
		logic [31:0] seq_out;
		logic [15:0] seg;
		logic [9:0]  pseq;
		logic [1:0]  fi;
		logic [19:0] ptotal;
		logic        epdu;
		logic [2:0]  mark;
		logic [23:0] qbytes;
		logic        last;
	} res_t;

	typedef struct {
		item_t it;
		bit    has_exp;
		res_t  exp;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic push = 0, pop = 0;
	logic [1:0] action = 0;
	logic [15:0] sdu_total_bytes = 0, sdu_payload_bytes = 0;
	logic [31:0] sdu_seq = 0;
	logic [19:0] pdu_bytes = 0;
	logic cfg_valid = 0;
	logic [1:0] cfg_index = 0;
	logic [23:0] cfg_data = 0;
	wire full, empty, cfg_ready;
	wire [1:0] kind, framing_info;
	wire accepted, empty_pdu, last;
	wire [31:0] sdu_seq_out;
	wire [15:0] segment_bytes;
	wire [9:0] pdu_seq;
	wire [19:0] pdu_total_bytes;
	wire [2:0] burst_mark;
	wire [23:0] queued_bytes_out;

	rlc_um_tx_segmenter dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// predictor state
	logic [15:0] st_total[DEPTH];
	logic [15:0] st_pay[DEPTH];
	logic [31:0] st_seq[DEPTH];
	int unsigned p_head, p_cnt, p_qb, p_frag_rem;
	bit p_frag_v, p_first_frag, p_burst;
	logic [9:0] p_pseq;
	cfg_t p_cfg;

	res_t expected_beats[$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 0;
	bit fixed_check = 0;
	res_t fixed_res;

	task automatic report(input string what, input res_t got, input res_t want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	function automatic void sub_bytes(input int unsigned b);
		p_qb = (b > p_qb) ? 0 : p_qb - b;
	endfunction

	task automatic segment_predict(input item_t it);
		res_t r[$];
		res_t x;
		int avail, h;
		int unsigned len, slen, take, sum;
		bit sf, ef, ok;
		case (it.act)
			ACT_ENQ: begin
				sum = p_qb + it.total;
				ok = p_cnt < DEPTH && sum <= 24'hFFFFFF &&
					(p_cfg.limit == 0 || sum < p_cfg.limit);
				if (ok) begin
					h = (p_head + p_cnt) % DEPTH;
					st_total[h] = it.total; st_pay[h] = it.payload; st_seq[h] = it.seq;
					p_cnt++; p_qb = sum;
				end
				x = '0; x.kind = KIND_ENQ; x.accepted = ok; x.seq_out = it.seq;
				r.push_back(x);
			end
			ACT_PDU: begin
				avail = int'(it.grant) - int'(p_cfg.hdr);
				len = 0; sf = p_first_frag; ef = 0;
				while (p_cnt > 0 && avail > 0) begin
					h = p_head;
					slen = p_frag_v ? p_frag_rem : st_pay[h];
					if (avail >= int'(slen)) begin
						take = slen; avail -= slen;
						p_frag_v = 0; p_frag_rem = 0;
						p_head = (p_head + 1) % DEPTH; p_cnt--;
						sub_bytes(st_total[h]); p_first_frag = 0;
					end else begin
						take = avail; p_frag_rem = slen - take; p_frag_v = 1;
						ef = 1; avail = 0; p_first_frag = 1;
					end
					len += take;
					x = '0; x.kind = KIND_SEG; x.seq_out = st_seq[h]; x.seg = take;
					r.push_back(x);
				end
				x = '0; x.kind = KIND_CLOSE;
				if (len == 0) x.epdu = 1;
				else begin
					x.pseq = p_pseq; x.fi = {sf, ef}; x.ptotal = p_cfg.hdr + len;
					p_pseq++;
					if (p_cfg.burst_en) begin
						if (p_cnt == 0) begin
							x.mark = p_burst ? BURST_STOP : BURST_INACTIVE; p_burst = 0;
						end else begin
							x.mark = p_burst ? BURST_ACTIVE : BURST_START; p_burst = 1;
						end
					end
				end
				r.push_back(x);
			end
			ACT_REM: begin
				x = '0; x.kind = KIND_REMCLR;
				if (p_cnt > 0) begin
					h = (p_head + p_cnt - 1) % DEPTH;
					x.accepted = 1; x.seq_out = st_seq[h];
					sub_bytes(st_total[h]); p_cnt--;
					if (p_cnt == 0 && p_frag_v) begin
						p_frag_v = 0; p_frag_rem = 0; p_first_frag = 0;
					end
				end
				r.push_back(x);
			end
			default: begin
				p_cnt = 0; p_head = 0; p_qb = 0;
				p_frag_v = 0; p_frag_rem = 0; p_first_frag = 0;
				x = '0; x.kind = KIND_REMCLR; x.accepted = 1;
				r.push_back(x);
			end
		endcase
		foreach (r[i]) begin
			r[i].qbytes = p_qb;
			r[i].last = (i == r.size() - 1);
			expected_beats.push_back(r[i]);
		end
	endtask

	// result side: stalls, occasional long hold-off
	always @(posedge clk) begin
		res_t got;
		cycles <= cycles + 1;
		if (pop && !empty) begin
			got = {kind, accepted, sdu_seq_out, segment_bytes, pdu_seq, framing_info,
				pdu_total_bytes, empty_pdu, burst_mark, queued_bytes_out, last};
			if (expected_beats.size() == 0) report("unexpected beat", got, '0);
			else begin
				if (got !== expected_beats[0]) report("field", got, expected_beats[0]);
				void'(expected_beats.pop_front());
			end
			if (fixed_check) begin
				if (got !== fixed_res) report("table", got, fixed_res);
				fixed_check <= 0;
			end
		end
		pop <= !hold_off && ($urandom_range(0, 3) != 0);
	end

	task automatic drive_item(input item_t it);
		push <= 1;
		action <= it.act; sdu_total_bytes <= it.total; sdu_payload_bytes <= it.payload;
		sdu_seq <= it.seq; pdu_bytes <= it.grant;
		do @(posedge clk); while (full);
		segment_predict(it);
	endtask

	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if (g > 0) begin
			push <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LIMIT: p_cfg.limit = val;
			REG_HDR:   p_cfg.hdr = val[3:0];
			default:   p_cfg.burst_en = val[0];
		endcase
	endtask

	function automatic item_t rand_item(input bit noise);
		item_t it;
		int s;
		s = $urandom_range(0, 99);
		it.act = (s < 50) ? ACT_ENQ : (s < 88) ? ACT_PDU : (s < 96) ? ACT_REM : ACT_CLR;
		if (noise) begin
			it.total = $urandom; it.payload = $urandom; it.grant = $urandom;
		end else begin
			it.payload = $urandom_range(0, 300);
			it.total = it.payload + $urandom_range(0, 4);
			it.grant = $urandom_range(0, 700);
		end
		it.seq = $urandom;
		return it;
	endfunction

	row_t dir_rows[$];

	task automatic add_row(input action_t a, input int tot, input int pay,
			input logic [31:0] sq, input int gr, input bit he, input res_t ex);
		row_t rw;
		rw.it.act = a; rw.it.total = tot; rw.it.payload = pay;
		rw.it.seq = sq; rw.it.grant = gr; rw.has_exp = he; rw.exp = ex;
		dir_rows.push_back(rw);
	endtask

	initial begin
		res_t e;
		item_t it;
		p_head = 0; p_cnt = 0; p_qb = 0; p_frag_rem = 0;
		p_frag_v = 0; p_first_frag = 0; p_burst = 0; p_pseq = 0;
		p_cfg.limit = 0; p_cfg.hdr = 2; p_cfg.burst_en = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset: empty PDU, remove on empty
		e = '0; e.kind = KIND_CLOSE; e.epdu = 1; e.last = 1;
		add_row(ACT_PDU, 0, 0, 0, 100, 1, e);
		e = '0; e.kind = KIND_REMCLR; e.last = 1;
		add_row(ACT_REM, 0, 0, 0, 0, 1, e);
		e = '0; e.kind = KIND_ENQ; e.accepted = 1; e.seq_out = 32'hFFFFFFFF;
		e.qbytes = 16'hFFFF; e.last = 1;
		add_row(ACT_ENQ, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 0, 1, e);
		add_row(ACT_ENQ, 10, 8, 32'h1, 0, 0, e);
		add_row(ACT_ENQ, 0, 0, 32'h2, 0, 0, e);
		add_row(ACT_PDU, 0, 0, 0, 2, 0, e);           // grant equals header
		add_row(ACT_PDU, 0, 0, 0, 1000, 0, e);        // cut head
		add_row(ACT_PDU, 0, 0, 0, 20'hFFFFF, 0, e);   // finish fragment, pop all
		add_row(ACT_ENQ, 50, 40, 32'hA5A5A5A5, 0, 0, e);
		add_row(ACT_ENQ, 30, 20, 32'h5A5A5A5A, 0, 0, e);
		add_row(ACT_PDU, 0, 0, 0, 12, 0, e);
		add_row(ACT_REM, 0, 0, 0, 0, 0, e);
		add_row(ACT_REM, 0, 0, 0, 0, 0, e);           // removes cut head
		add_row(ACT_ENQ, 5, 5, 32'h3, 0, 0, e);
		add_row(ACT_ENQ, 5, 5, 32'h4, 0, 0, e);
		e = '0; e.kind = KIND_REMCLR; e.accepted = 1; e.last = 1;
		add_row(ACT_CLR, 0, 0, 0, 0, 1, e);
		for (int i = 0; i < 17; i++) add_row(ACT_ENQ, 1, 1, i, 0, 0, e); // store full
		add_row(ACT_PDU, 0, 0, 0, 20'hFFFFF, 0, e);   // most segments
		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_exp) begin
				drain();
				fixed_res = dir_rows[i].exp; fixed_check = 1;
			end
			drive_item(dir_rows[i].it);
			if (dir_rows[i].has_exp) drain();
		end
		drain();

		// phases over register settings, extremes included
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin write_reg(REG_LIMIT, 24'hFFFFFF); write_reg(REG_HDR, 0);
					write_reg(REG_BURST, 0); end
				1: begin write_reg(REG_LIMIT, 900); write_reg(REG_HDR, 15);
					write_reg(REG_BURST, 1); end
				2: begin write_reg(REG_LIMIT, 1); write_reg(REG_HDR, 3); end
				default: begin write_reg(REG_LIMIT, 0); write_reg(REG_HDR, 2); end
			endcase
			cfg_valid <= 0;
			for (int n = 0; n < 34; n++) begin
				if (ph == 1 && n == 5) begin
					hold_off = 1;
					fork
						begin repeat (300) @(posedge clk); hold_off = 0; end
					join_none
				end
				if (n == 20) begin
					push <= 0;
					while (expected_beats.size() != 0) @(posedge clk);
				end
				it = rand_item($urandom_range(0, 9) == 0);
				drive_item(it);
				sender_gap();
			end
		end
		drain();
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	always @(posedge clk)
		if (cycles > CYC_MAX) begin
			$display("Regression FAIL");
			$finish;
		end

endmodule

`default_nettype wire

>>> files.f
hdl/rlcseg_pkg.sv
hdl/rlcseg_front.sv
hdl/rlcseg_back.sv
hdl/rlc_um_tx_segmenter.sv
tb/testbench.sv
